@@ rtl/core/kmc_pkg.sv @@
`default_nettype none

package kmc_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int FRAC_BITS    = 32;
  localparam int DIV_STEPS    = 64 + FRAC_BITS;
  localparam int DIV_LAT      = DIV_STEPS + 2;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314856;

  localparam logic signed [63:0] Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

  localparam logic SPIN_REG = 1'b0;

  typedef struct packed {
    logic signed [63:0] v;
    logic               st;
  } qres_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } qpp_t;

  function automatic logic [33:0] atan_q29(input int i);
    logic [33:0] r;
    case (i)
      0:  r = 34'd421657428;
      1:  r = 34'd248918915;
      2:  r = 34'd131521918;
      3:  r = 34'd66762579;
      4:  r = 34'd33510843;
      5:  r = 34'd16771758;
      6:  r = 34'd8387925;
      7:  r = 34'd4194219;
      8:  r = 34'd2097141;
      9:  r = 34'd1048575;
      10: r = 34'd524288;
      11: r = 34'd262144;
      12: r = 34'd131072;
      13: r = 34'd65536;
      14: r = 34'd32768;
      15: r = 34'd16384;
      16: r = 34'd8192;
      17: r = 34'd4096;
      18: r = 34'd2048;
      19: r = 34'd1024;
      20: r = 34'd512;
      21: r = 34'd256;
      22: r = 34'd128;
      23: r = 34'd64;
      24: r = 34'd32;
      25: r = 34'd16;
      26: r = 34'd8;
      27: r = 34'd4;
      28: r = 34'd2;
      29: r = 34'd1;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] q_mag(input logic signed [63:0] v);
    logic [63:0] u;
    u = v;
    return v[63] ? (~u + 64'd1) : u;
  endfunction

  function automatic qres_t q_finish(input logic neg, input logic [63:0] mag, input logic big);
    qres_t r;
    r.st = 1'b0;
    if (!big && !neg && !mag[63]) begin
      r.v = mag;
    end else if (!big && neg && (!mag[63] || mag[62:0] == 63'd0)) begin
      r.v = ~mag + 64'd1;
    end else begin
      r.st = 1'b1;
      r.v  = neg ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  function automatic qres_t q_add(input logic signed [63:0] x, input logic signed [63:0] y);
    qres_t r;
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    r.st = s[64] != s[63];
    r.v  = r.st ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
    return r;
  endfunction

  function automatic qres_t q_sub(input logic signed [63:0] x, input logic signed [63:0] y);
    qres_t r;
    logic signed [64:0] s;
    s = {x[63], x} - {y[63], y};
    r.st = s[64] != s[63];
    r.v  = r.st ? (s[64] ? Q_MIN : Q_MAX) : s[63:0];
    return r;
  endfunction

  function automatic qpp_t q_mul_pp(input logic signed [63:0] x, input logic signed [63:0] y);
    qpp_t p;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] b0;
    logic [31:0] b1;
    ux = q_mag(x);
    uy = q_mag(y);
    a0 = ux[31:0];
    a1 = ux[63:32];
    b0 = uy[31:0];
    b1 = uy[63:32];
    p.neg = x[63] ^ y[63];
    p.p00 = {32'd0, a0} * {32'd0, b0};
    p.p01 = {32'd0, a0} * {32'd0, b1};
    p.p10 = {32'd0, a1} * {32'd0, b0};
    p.p11 = {32'd0, a1} * {32'd0, b1};
    return p;
  endfunction

  function automatic qres_t q_mul_fin(input qpp_t p);
    logic [63:0] mid;
    logic [63:0] hi;
    mid = {32'd0, p.p00[63:32]} + {32'd0, p.p01[31:0]} + {32'd0, p.p10[31:0]};
    hi  = p.p11 + {32'd0, p.p01[63:32]} + {32'd0, p.p10[63:32]} + {32'd0, mid[63:32]};
    return q_finish(p.neg, {hi[31:0], mid[31:0]}, hi[63:32] != 32'd0);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/kmc_div.sv @@
`default_nettype none

module kmc_div
  import kmc_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic signed [63:0] quo,
  output logic               flag
);

  localparam int NUM_W = DIV_STEPS - FRAC_BITS;

  logic [63:0] rem [DIV_STEPS];
  logic [63:0] q   [DIV_STEPS+1];
  logic [63:0] un  [NUM_W];
  logic [63:0] ud  [DIV_STEPS];
  logic        big [DIV_STEPS+1];
  logic        neg [DIV_STEPS+1];
  logic        dz  [DIV_STEPS+1];
  logic        nn  [DIV_STEPS+1];
  qres_t       fin;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 64'd0;
      q[0]   <= 64'd0;
      un[0]  <= q_mag(num);
      ud[0]  <= q_mag(den);
      big[0] <= 1'b0;
      neg[0] <= num[63] ^ den[63];
      dz[0]  <= den == 64'sd0;
      nn[0]  <= num[63];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic        dbit;
    logic [63:0] rsh;
    logic        ge;

    if (j < NUM_W) begin : g_num
      assign dbit = un[j][NUM_W-1-j];
    end else begin : g_frac
      assign dbit = 1'b0;
    end

    assign rsh = {rem[j][62:0], dbit};
    assign ge  = rsh >= ud[j];

    always_ff @(posedge clk) begin
      if (en) begin
        q[j+1]   <= {q[j][62:0], ge};
        big[j+1] <= big[j] | q[j][63];
        neg[j+1] <= neg[j];
        dz[j+1]  <= dz[j];
        nn[j+1]  <= nn[j];
      end
    end

    if (j < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? (rsh - ud[j]) : rsh;
          ud[j+1]  <= ud[j];
        end
      end
    end

    if (j < NUM_W - 1) begin : g_un
      always_ff @(posedge clk) begin
        if (en) begin
          un[j+1] <= un[j];
        end
      end
    end
  end

  always_comb begin
    fin = q_finish(neg[DIV_STEPS], q[DIV_STEPS], big[DIV_STEPS]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dz[DIV_STEPS]) begin
        quo  <= nn[DIV_STEPS] ? Q_MIN : Q_MAX;
        flag <= 1'b1;
      end else begin
        quo  <= fin.v;
        flag <= fin.st;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kerr_metric_components.sv @@
// Kerr metric components in Boyer-Lindquist coordinates, unit mass.
// The spin is written through the APB port at byte address 0; the user must write
// it only while the block is idle, which the block does not enforce. Reset sets it
// to zero. Each transfer on the item channel carries a radius (Q12.20) and a polar
// angle (Q2.29 radians); each transfer on the result channel carries g_tt, g_rr,
// g_thetatheta, g_phiphi and g_tphi in Q31.32 and a status bit that is set when
// sigma or delta is zero or a result saturated. The block is a single pipeline: a
// 30-stage CORDIC, multipliers that register their 32 by 32 partial products and
// then the product, and four restoring dividers that retire one quotient bit per
// stage over 96 stages. One item is taken in every cycle while no result is stalled.
// When the result channel is stalled with a result waiting, the whole pipeline
// holds, and item_stall is raised in the same cycle, so nothing is lost or
// repeated. Reset empties the pipeline; no result is shown until items enter.
`default_nettype none

module kerr_metric_components
  import kmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [31:0]        radius,
  input  logic [30:0]        polar_angle,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [63:0] g_time_time,
  output logic signed [63:0] g_radial_radial,
  output logic signed [63:0] g_polar_polar,
  output logic signed [63:0] g_azimuth_azimuth,
  output logic signed [63:0] g_time_azimuth,
  output logic               status
);

  typedef struct packed {
    logic signed [63:0] sigma;
    logic signed [63:0] rra;
    logic signed [63:0] s2;
    logic               st;
    logic               sz;
  } side_t;

  logic signed [31:0] spin;
  logic signed [63:0] a_q;
  logic               advance;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == SPIN_REG) ? spin : 32'd0;
  assign advance = !(result_valid && result_stall);
  assign item_stall = !advance;
  assign a_q = {{30{spin[31]}}, spin, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      spin <= 32'sd0;
    end else if (psel && penable && pwrite && paddr[2] == SPIN_REG) begin
      spin <= pwdata;
    end
  end

  // CORDIC
  logic signed [33:0] cx [CORDIC_STEPS+1];
  logic signed [33:0] cy [CORDIC_STEPS+1];
  logic signed [33:0] cz [CORDIC_STEPS+1];
  logic               cf [CORDIC_STEPS+1];
  logic [31:0]        cr [CORDIC_STEPS+1];
  logic               cv [CORDIC_STEPS+1];
  logic signed [33:0] theta;
  logic               flip;

  assign theta = {3'b000, polar_angle};
  assign flip  = theta > HALF_PI_Q29;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (advance) begin
      cv[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cx[0] <= CORDIC_GAIN;
      cy[0] <= 34'sd0;
      cz[0] <= flip ? (PI_Q29 - theta) : theta;
      cf[0] <= flip;
      cr[0] <= radius;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;

    assign dx = cy[k] >>> k;
    assign dy = cx[k] >>> k;
    assign at = atan_q29(k);

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (advance) begin
        cv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        if (!cz[k][33]) begin
          cx[k+1] <= cx[k] - dx;
          cy[k+1] <= cy[k] + dy;
          cz[k+1] <= cz[k] - at;
        end else begin
          cx[k+1] <= cx[k] + dx;
          cy[k+1] <= cy[k] - dy;
          cz[k+1] <= cz[k] + at;
        end
        cf[k+1] <= cf[k];
        cr[k+1] <= cr[k];
      end
    end
  end

  logic signed [63:0] sn;
  logic signed [63:0] cs;
  logic signed [33:0] xc;
  logic signed [63:0] c_r;
  logic signed [63:0] c_tr;

  assign xc   = cf[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  assign sn   = {{28{cy[CORDIC_STEPS][33]}}, cy[CORDIC_STEPS], 2'b00};
  assign cs   = {{28{xc[33]}}, xc, 2'b00};
  assign c_r  = {20'd0, cr[CORDIC_STEPS], 12'd0};
  assign c_tr = {19'd0, cr[CORDIC_STEPS], 13'd0};

  // First products
  qpp_t        m1a_r2, m1a_a2, m1a_c2, m1a_s2, m1a_ra;
  logic [31:0] m1a_rad;
  logic        m1a_v;
  qres_t       f_r2, f_a2, f_c2, f_s2, f_ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1a_v <= 1'b0;
    end else if (advance) begin
      m1a_v <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m1a_r2  <= q_mul_pp(c_r, c_r);
      m1a_a2  <= q_mul_pp(a_q, a_q);
      m1a_c2  <= q_mul_pp(cs, cs);
      m1a_s2  <= q_mul_pp(sn, sn);
      m1a_ra  <= q_mul_pp(c_tr, a_q);
      m1a_rad <= cr[CORDIC_STEPS];
    end
  end

  always_comb begin
    f_r2 = q_mul_fin(m1a_r2);
    f_a2 = q_mul_fin(m1a_a2);
    f_c2 = q_mul_fin(m1a_c2);
    f_s2 = q_mul_fin(m1a_s2);
    f_ra = q_mul_fin(m1a_ra);
  end

  logic signed [63:0] m1b_r2, m1b_a2, m1b_c2, m1b_s2, m1b_ra;
  logic [31:0]        m1b_rad;
  logic               m1b_st;
  logic               m1b_v;
  logic signed [63:0] m1b_tr;

  assign m1b_tr = {19'd0, m1b_rad, 13'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      m1b_v <= 1'b0;
    end else if (advance) begin
      m1b_v <= m1a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m1b_r2  <= f_r2.v;
      m1b_a2  <= f_a2.v;
      m1b_c2  <= f_c2.v;
      m1b_s2  <= f_s2.v;
      m1b_ra  <= f_ra.v;
      m1b_st  <= f_r2.st | f_a2.st | f_c2.st | f_s2.st | f_ra.st;
      m1b_rad <= m1a_rad;
    end
  end

  // Second products
  qpp_t               m2a_ac, m2a_ta, m2a_nm;
  logic signed [63:0] m2a_r2, m2a_a2, m2a_s2;
  logic [31:0]        m2a_rad;
  logic               m2a_st;
  logic               m2a_v;
  qres_t              f_ac, f_ta, f_nm;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2a_v <= 1'b0;
    end else if (advance) begin
      m2a_v <= m1b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m2a_ac  <= q_mul_pp(m1b_a2, m1b_c2);
      m2a_ta  <= q_mul_pp(m1b_tr, m1b_a2);
      m2a_nm  <= q_mul_pp(m1b_ra, m1b_s2);
      m2a_r2  <= m1b_r2;
      m2a_a2  <= m1b_a2;
      m2a_s2  <= m1b_s2;
      m2a_st  <= m1b_st;
      m2a_rad <= m1b_rad;
    end
  end

  always_comb begin
    f_ac = q_mul_fin(m2a_ac);
    f_ta = q_mul_fin(m2a_ta);
    f_nm = q_mul_fin(m2a_nm);
  end

  logic signed [63:0] m2b_ac, m2b_ta, m2b_nm, m2b_r2, m2b_a2, m2b_s2;
  logic [31:0]        m2b_rad;
  logic               m2b_st;
  logic               m2b_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2b_v <= 1'b0;
    end else if (advance) begin
      m2b_v <= m2a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m2b_ac  <= f_ac.v;
      m2b_ta  <= f_ta.v;
      m2b_nm  <= f_nm.v;
      m2b_r2  <= m2a_r2;
      m2b_a2  <= m2a_a2;
      m2b_s2  <= m2a_s2;
      m2b_st  <= m2a_st | f_ac.st | f_ta.st | f_nm.st;
      m2b_rad <= m2a_rad;
    end
  end

  // Sigma, the r^2 + a^2 sum and the g_tphi numerator
  qres_t f_sg, f_rra, f_num;

  always_comb begin
    f_sg  = q_add(m2b_r2, m2b_ac);
    f_rra = q_add(m2b_r2, m2b_a2);
    f_num = q_sub(64'sd0, m2b_nm);
  end

  logic signed [63:0] a1_sigma, a1_rra, a1_num, a1_s2;
  qpp_t               a1_t;
  logic [31:0]        a1_rad;
  logic               a1_st;
  logic               a1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_v <= 1'b0;
    end else if (advance) begin
      a1_v <= m2b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a1_sigma <= f_sg.v;
      a1_rra   <= f_rra.v;
      a1_num   <= f_num.v;
      a1_t     <= q_mul_pp(m2b_ta, m2b_s2);
      a1_s2    <= m2b_s2;
      a1_rad   <= m2b_rad;
      a1_st    <= m2b_st | f_sg.st | f_rra.st | f_num.st;
    end
  end

  qres_t              f_dl, f_t;
  logic signed [63:0] a1_tr;

  assign a1_tr = {19'd0, a1_rad, 13'd0};

  always_comb begin
    f_dl = q_sub(a1_rra, a1_tr);
    f_t  = q_mul_fin(a1_t);
  end

  logic signed [63:0] a2_sigma, a2_rra, a2_num, a2_s2, a2_delta, a2_t;
  logic [31:0]        a2_rad;
  logic               a2_st;
  logic               a2_v;
  logic signed [63:0] a2_tr;

  assign a2_tr = {19'd0, a2_rad, 13'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      a2_v <= 1'b0;
    end else if (advance) begin
      a2_v <= a1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a2_sigma <= a1_sigma;
      a2_rra   <= a1_rra;
      a2_num   <= a1_num;
      a2_s2    <= a1_s2;
      a2_delta <= f_dl.v;
      a2_t     <= f_t.v;
      a2_rad   <= a1_rad;
      a2_st    <= a1_st | f_dl.st | f_t.st;
    end
  end

  // Dividers and the matching side line
  logic signed [63:0] q_rr, q_tp, q_tt, q_pp;
  logic               fl_rr, fl_tp, fl_tt, fl_pp;

  kmc_div u_div_rr (.clk, .en(advance), .num(a2_sigma), .den(a2_delta), .quo(q_rr), .flag(fl_rr));
  kmc_div u_div_tp (.clk, .en(advance), .num(a2_num),   .den(a2_sigma), .quo(q_tp), .flag(fl_tp));
  kmc_div u_div_tt (.clk, .en(advance), .num(a2_tr),    .den(a2_sigma), .quo(q_tt), .flag(fl_tt));
  kmc_div u_div_pp (.clk, .en(advance), .num(a2_t),     .den(a2_sigma), .quo(q_pp), .flag(fl_pp));

  side_t dl [DIV_LAT];
  logic  dv [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (advance) begin
      dv[0] <= a2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dl[0] <= '{sigma: a2_sigma, rra: a2_rra, s2: a2_s2, st: a2_st, sz: a2_sigma == 64'sd0};
    end
  end

  for (genvar n = 1; n < DIV_LAT; n++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[n] <= 1'b0;
      end else if (advance) begin
        dv[n] <= dv[n-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dl[n] <= dl[n-1];
      end
    end
  end

  // g_tt and the g_phiphi bracket
  side_t dend;
  qres_t f_gtt, f_u;

  assign dend = dl[DIV_LAT-1];

  always_comb begin
    f_gtt = q_sub(q_tt, ONE_Q32);
    f_u   = q_add(dend.rra, q_pp);
  end

  logic signed [63:0] p1_gtt, p1_grr, p1_gtp, p1_sigma, p1_s2, p1_u;
  logic               p1_st, p1_sz, p1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else if (advance) begin
      p1_v <= dv[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_gtt   <= dend.sz ? Q_MAX : f_gtt.v;
      p1_grr   <= q_rr;
      p1_gtp   <= q_tp;
      p1_sigma <= dend.sigma;
      p1_s2    <= dend.s2;
      p1_u     <= f_u.v;
      p1_sz    <= dend.sz;
      p1_st    <= dend.st | fl_rr | fl_tp | fl_tt | fl_pp | f_gtt.st | f_u.st;
    end
  end

  qpp_t               p2_pp;
  logic signed [63:0] p2_gtt, p2_grr, p2_gtp, p2_sigma;
  logic               p2_st, p2_sz, p2_v;
  qres_t              f_gpp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else if (advance) begin
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_pp    <= q_mul_pp(p1_s2, p1_u);
      p2_gtt   <= p1_gtt;
      p2_grr   <= p1_grr;
      p2_gtp   <= p1_gtp;
      p2_sigma <= p1_sigma;
      p2_st    <= p1_st;
      p2_sz    <= p1_sz;
    end
  end

  always_comb begin
    f_gpp = q_mul_fin(p2_pp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      g_time_time       <= p2_gtt;
      g_radial_radial   <= p2_grr;
      g_polar_polar     <= p2_sigma;
      g_azimuth_azimuth <= p2_sz ? Q_MAX : f_gpp.v;
      g_time_azimuth    <= p2_gtp;
      status            <= p2_st | f_gpp.st;
    end
  end

  a_item_enters : assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> cv[0])
    else $error("accepted item did not enter the pipeline");

  a_sigma_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && g_polar_polar == 64'sd0) |-> (status && g_time_time == Q_MAX))
    else $error("zero sigma without saturation and status");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(dv[DIV_LAT-1]) && $stable(p1_v)))
    else $error("pipeline moved while the result was stalled");

endmodule

`default_nettype wire

@@ dv/kerr_metric_components_checker.sv @@
`timescale 1ns / 100ps

module kerr_metric_components_checker
  import kmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic [31:0]        radius,
  input  logic [30:0]        polar_angle,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic signed [63:0] g_time_time,
  input  logic signed [63:0] g_radial_radial,
  input  logic signed [63:0] g_polar_polar,
  input  logic signed [63:0] g_azimuth_azimuth,
  input  logic signed [63:0] g_time_azimuth,
  input  logic               status,
  output int                 failures,
  output int                 pending
);

  typedef struct {
    logic signed [63:0] tt;
    logic signed [63:0] rr;
    logic signed [63:0] thth;
    logic signed [63:0] phph;
    logic signed [63:0] tph;
    logic               st;
  } metric_t;

  localparam logic [2:0] SPIN_ADDR = {SPIN_REG, 2'b00};

  metric_t           metric_q[$];
  logic signed [31:0] spin_value;

  function automatic logic signed [63:0] clamp_mag(input logic neg, input logic [63:0] mag,
                                                   input logic big, inout logic st);
    if (!big && !neg && !mag[63]) begin
      return mag;
    end
    if (!big && neg && mag <= 64'h8000_0000_0000_0000) begin
      return -mag;
    end
    st = 1'b1;
    return neg ? Q_MIN : Q_MAX;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                                input logic signed [63:0] y, inout logic st);
    logic [127:0] prod;
    prod = {64'd0, abs64(x)} * {64'd0, abs64(y)};
    return clamp_mag((x < 0) != (y < 0), prod[95:32], prod[127:96] != 0, st);
  endfunction

  function automatic logic signed [63:0] fx_div(input logic signed [63:0] n,
                                                input logic signed [63:0] d, inout logic st);
    logic [127:0] quo;
    if (d == 0) begin
      st = 1'b1;
      return n >= 0 ? Q_MAX : Q_MIN;
    end
    quo = {32'd0, abs64(n), 32'd0} / {64'd0, abs64(d)};
    return clamp_mag((n < 0) != (d < 0), quo[63:0], quo[127:64] != 0, st);
  endfunction

  function automatic logic signed [63:0] fx_add(input logic signed [63:0] x,
                                                input logic signed [63:0] y, inout logic st);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      st = 1'b1;
      return s[64] ? Q_MIN : Q_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] fx_sub(input logic signed [63:0] x,
                                                input logic signed [63:0] y, inout logic st);
    logic signed [64:0] s;
    s = {x[63], x} - {y[63], y};
    if (s[64] != s[63]) begin
      st = 1'b1;
      return s[64] ? Q_MIN : Q_MAX;
    end
    return s[63:0];
  endfunction

  function automatic metric_t kerr_metric(input logic [31:0] rad, input logic [30:0] ang,
                                          input logic signed [31:0] a_reg);
    metric_t m;
    logic signed [63:0] x, y, z, dx, dy, sn, cs;
    logic signed [63:0] r, a, two_r, r2, a2, c2, s2, sigma, rra, delta, t;
    logic flip;
    logic st;
    st = 1'b0;
    x = 64'(CORDIC_GAIN);
    y = 0;
    z = {33'd0, ang};
    flip = z > 64'(HALF_PI_Q29);
    if (flip) begin
      z = 64'(PI_Q29) - z;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - 64'(atan_q29(i));
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + 64'(atan_q29(i));
      end
    end
    sn = y * 4;
    cs = (flip ? -x : x) * 4;
    r = {20'd0, rad, 12'd0};
    a = 64'(a_reg) * 4;
    two_r = r * 2;
    r2 = fx_mul(r, r, st);
    a2 = fx_mul(a, a, st);
    c2 = fx_mul(cs, cs, st);
    s2 = fx_mul(sn, sn, st);
    sigma = fx_add(r2, fx_mul(a2, c2, st), st);
    rra = fx_add(r2, a2, st);
    delta = fx_sub(rra, two_r, st);
    m.rr = fx_div(sigma, delta, st);
    m.tph = fx_div(fx_sub(0, fx_mul(fx_mul(two_r, a, st), s2, st), st), sigma, st);
    if (sigma == 0) begin
      st = 1'b1;
      m.tt = Q_MAX;
      m.phph = Q_MAX;
    end else begin
      m.tt = fx_sub(fx_div(two_r, sigma, st), ONE_Q32, st);
      t = fx_mul(fx_mul(two_r, a2, st), s2, st);
      m.phph = fx_mul(s2, fx_add(rra, fx_div(t, sigma, st), st), st);
    end
    if (delta == 0) begin
      st = 1'b1;
    end
    m.thth = sigma;
    m.st = st;
    return m;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %h, expected %h", $realtime, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    metric_t want;
    if (rst) begin
      failures = 0;
      spin_value = 0;
      metric_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == SPIN_ADDR) begin
        spin_value = pwdata;
      end
      if (result_valid && !result_stall) begin
        if (metric_q.size() == 0) begin
          report_mismatch("result transfer with none expected", 0, 0);
        end else begin
          want = metric_q.pop_front();
          if (g_time_time !== want.tt) report_mismatch("g_time_time", g_time_time, want.tt);
          if (g_radial_radial !== want.rr) begin
            report_mismatch("g_radial_radial", g_radial_radial, want.rr);
          end
          if (g_polar_polar !== want.thth) begin
            report_mismatch("g_polar_polar", g_polar_polar, want.thth);
          end
          if (g_azimuth_azimuth !== want.phph) begin
            report_mismatch("g_azimuth_azimuth", g_azimuth_azimuth, want.phph);
          end
          if (g_time_azimuth !== want.tph) begin
            report_mismatch("g_time_azimuth", g_time_azimuth, want.tph);
          end
          if (status !== want.st) report_mismatch("status", status, want.st);
        end
      end
      if (item_valid && !item_stall) begin
        metric_q.push_back(kerr_metric(radius, polar_angle, spin_value));
      end
    end
    pending = metric_q.size();
  end

endmodule

@@ dv/kerr_metric_components_tb.sv @@
`timescale 1ns / 100ps

module kerr_metric_components_tb
  import kmc_pkg::*;
;

  localparam logic [2:0] SPIN_ADDR  = {SPIN_REG, 2'b00};
  localparam logic [30:0] PI_ANGLE  = 31'd1686629713;
  localparam logic [30:0] HALF_PI   = 31'd843314856;
  localparam int          IDLE_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [31:0]        radius = '0;
  logic [30:0]        polar_angle = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [63:0] g_time_time;
  logic signed [63:0] g_radial_radial;
  logic signed [63:0] g_polar_polar;
  logic signed [63:0] g_azimuth_azimuth;
  logic signed [63:0] g_time_azimuth;
  logic               status;
  int                 failures;
  int                 pending;
  int                 idle_cycles = 0;
  logic               steady = 1'b0;

  always #5 clk = ~clk;

  kerr_metric_components dut (.*);

  kerr_metric_components_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("kerr_metric_components: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(99);
    if (steady || pick < 65) return 0;
    if (pick < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  initial begin
    @(negedge clk);
    forever begin
      if ($urandom_range(9) < 2) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(200, 50)) @(negedge clk);
      end else begin
        repeat ($urandom_range(60, 10)) begin
          result_stall <= 1'b1;
          repeat (gap_length() + 1) @(negedge clk);
          result_stall <= 1'b0;
          repeat (gap_length() + 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_point(input logic [31:0] rad, input logic [30:0] ang);
    int gap;
    @(negedge clk);
    item_valid <= 1'b1;
    radius <= rad;
    polar_angle <= ang;
    do @(posedge clk); while (item_stall);
    gap = gap_length();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_spin(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SPIN_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    wait (pending == 0);
    repeat (160) @(posedge clk);
  endtask

  function automatic logic [30:0] random_angle();
    if ($urandom_range(9) == 0) return 31'($urandom());
    return 31'($urandom_range(PI_ANGLE));
  endfunction

  function automatic logic [31:0] random_radius();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0080_0000);
      2: return $urandom_range(32'h0030_0000, 32'h0008_0000);
      default: return $urandom_range(32'h0400_0000);
    endcase
  endfunction

  initial begin
    logic [31:0] spins[7];
    spins[0] = 32'h0000_0000;
    spins[1] = 32'h4000_0000;
    spins[2] = 32'hC000_0000;
    spins[3] = $urandom_range(32'h4000_0000);
    spins[4] = 32'h7FFF_FFFF;
    spins[5] = 32'h8000_0000;
    spins[6] = -$urandom_range(32'h4000_0000);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        drain();
        write_spin(spins[p]);
      end
      if (p < 2) begin
        send_point(32'd0, 31'd0);
        send_point(32'd0, HALF_PI);
        send_point(32'hFFFF_FFFF, 31'd0);
        send_point(32'hFFFF_FFFF, HALF_PI);
        send_point(32'h0020_0000, 31'd0);
        send_point(32'h0010_0000, HALF_PI);
        send_point(32'h0010_0000, PI_ANGLE);
        send_point(32'h0008_0000, 31'h7FFF_FFFF);
        send_point(32'h5555_5555, 31'h2AAA_AAAA);
        send_point(32'hAAAA_AAAA, 31'h5555_5555);
        send_point(32'h0000_0001, HALF_PI + 31'd1);
      end
      for (int n = 0; n < 250; n++) begin
        if (n % 60 == 0) steady = $urandom_range(3) == 0;
        send_point(random_radius(), random_angle());
      end
      steady = 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("kerr_metric_components: match");
    end else begin
      $display("kerr_metric_components: mismatch");
    end
    $finish;
  end

endmodule
